// ----- sv/adcsc_pkg.sv -----
// Shared types, codes and constants of the ADC scan and averaging block.
`timescale 1ns / 1ps

package adcsc_pkg;

	// Fixed field widths of the stream words and the configuration port.
	localparam int FUNC_W     = 3;
	localparam int CHAN_W     = 3;
	localparam int SAMPLE_IN_W = 12;
	localparam int RV_W       = 16;
	localparam int MV_W       = 12;
	localparam int NUMCH_W    = 4;
	localparam int SHIFT_W    = 3;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 12;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	// Operation codes carried in the input sideband.
	localparam logic [FUNC_W-1:0] FUNC_POLL  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_START = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_PAUSE = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_AVG   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_MV    = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] CFG_NUM_CH  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_SHIFT   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_AUTO    = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_REF_CH  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_REF_MV  = 3'd4;

	// Configuration values after reset.
	localparam logic [NUMCH_W-1:0] RST_NUM_CH = 4'd8;
	localparam logic [SHIFT_W-1:0] RST_SHIFT  = 3'd3;
	localparam logic               RST_AUTO   = 1'b1;
	localparam logic [CHAN_W-1:0]  RST_REF_CH = 3'd6;
	localparam logic [MV_W-1:0]    RST_REF_MV = 12'd1650;

	// Saturated millivolt reading.
	localparam logic [RV_W-1:0] RV_SAT = 16'hFFFF;

	// Which channel the filter memory is read for.
	typedef enum logic [1:0] {
		RD_SCAN = 2'd0,
		RD_CHAN = 2'd1,
		RD_REF  = 2'd2
	} rd_sel_t;

	// One result word, start_conv in the lowest bit.
	typedef struct packed {
		logic [RV_W-1:0]   read_value;
		logic              scan_done;
		logic              release_conv;
		logic [CHAN_W-1:0] conv_channel;
		logic              start_conv;
	} out_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    latch;
		logic    poll_norm;
		logic    poll_start;
		logic    scan_start;
		logic    scan_pause;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    fold_sum;
		logic    fold_write;
		logic    res_avg;
		logic    cap_den;
		logic    mul;
		logic    div_start;
		logic    out_load;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              conv_done;
		logic              scan_en;
		logic              pending;
		logic              div_busy;
		logic              div_done;
		logic              out_free;
	} dp_status_t;

endpackage

// ----- sv/adc_scan_with_channel_averaging.sv -----
// Top level of the ADC scan controller with per-channel leaky-sum averaging.
`timescale 1ns / 1ps

// Usage: the slave stream takes one command word per handshake; s_tuser holds the
// operation (poll, start scan, pause scan, read average, read millivolts) and
// s_tdata the converter done flag, the sample and the channel asked about.
// Every accepted word gives exactly one result word on the master stream.
// Words are handled one at a time. Each word is latched, decoded and then passes the
// result state; a sample fold first runs the fold-sum and fold-write states, an average
// read the average state, and a millivolt read the reference, multiply, divider start
// and divider wait states, the divider making one quotient bit per cycle.
// The filter memory has one read port, so a millivolt read fetches the reference
// and then the channel average, from the decode and reference states.
// The next word is accepted while a finished result still waits in the output
// register; if the receiver stalls, processing stops before that result would
// be overwritten, and s_tready stays low until the state machine is back in idle.
// Reset clears the scan state and marks every channel average as zero, and loads
// the configuration defaults. Write configuration only while the block is idle.
module adc_scan_with_channel_averaging #(
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 12,
	parameter int SUM_BITS     = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [adcsc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [adcsc_pkg::CFG_DATA_W-1:0] cfg_data,
	// Command stream.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata fields from bit 0: conv_done[0], sample[12:1], channel[15:13].
	input  logic [adcsc_pkg::IN_DATA_W-1:0]  s_tdata,
	// s_tuser fields from bit 0: func[2:0].
	input  logic [adcsc_pkg::FUNC_W-1:0]     s_tuser,
	// Result stream.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata fields from bit 0: start_conv[0], conv_channel[3:1], release_conv[4],
	// scan_done[5], read_value[21:6], zero fill [23:22].
	output logic [adcsc_pkg::OUT_DATA_W-1:0] m_tdata
);

	adcsc_pkg::ctrl_cmd_t  cmd;
	adcsc_pkg::dp_status_t sts;

	adcsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	adcsc_datapath #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.SUM_BITS     (SUM_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

// ----- sv/adcsc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module adcsc_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/adcsc_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module adcsc_div #(
	parameter int DEN_W = 12,
	parameter int NUM_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CW = $clog2(NUM_W + 1);

	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// Shift the next dividend bit into the remainder and try a subtract.
	assign trial = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, divisor});

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, divisor}) : trial;
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- sv/adcsc_datapath.sv -----
// Datapath: configuration, scan state, filter memory, divider and result words.
`timescale 1ns / 1ps

module adcsc_datapath #(
	parameter int MAX_CHANNELS = 8,
	parameter int SAMPLE_BITS  = 12,
	parameter int SUM_BITS     = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [adcsc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [adcsc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [adcsc_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic [adcsc_pkg::FUNC_W-1:0]        s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [adcsc_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  adcsc_pkg::ctrl_cmd_t                cmd,
	output adcsc_pkg::dp_status_t               sts
);

	localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
	localparam int WORD_W = SUM_BITS + SAMPLE_BITS;
	localparam int PROD_W = SAMPLE_BITS + adcsc_pkg::MV_W;
	localparam logic [SUM_BITS-1:0] SAMPLE_MAX_S = SUM_BITS'({SAMPLE_BITS{1'b1}});

	// Configuration registers.
	logic [adcsc_pkg::NUMCH_W-1:0] num_ch_q;
	logic [adcsc_pkg::SHIFT_W-1:0] shift_q;
	logic                          auto_q;
	logic [adcsc_pkg::CHAN_W-1:0]  ref_ch_q;
	logic [adcsc_pkg::MV_W-1:0]    ref_mv_q;

	// Scan state and filter valid bits.
	logic                    scan_en_q;
	logic                    pend_q;
	logic [IDX_W-1:0]        scan_idx_q;
	logic [MAX_CHANNELS-1:0] valid_q;
	logic                    rd_vld_q;

	// Latched item.
	logic [adcsc_pkg::FUNC_W-1:0]      func_q;
	logic                              done_q;
	logic [adcsc_pkg::SAMPLE_IN_W-1:0] smp_q;
	logic [adcsc_pkg::CHAN_W-1:0]      ch_q;

	// Working registers.
	logic [SUM_BITS-1:0]    sum_q;
	logic [SAMPLE_BITS-1:0] den_q;
	logic [PROD_W-1:0]      prod_q;
	adcsc_pkg::out_word_t   res_q;
	adcsc_pkg::out_word_t   out_q;
	logic                   out_vld_q;

	logic [CNT_W-1:0]       active;
	logic [IDX_W-1:0]       idx_eff;
	logic [CNT_W-1:0]       idx_next;
	logic                   wrap;
	logic                   ch_bad;
	logic                   ref_bad;
	logic [IDX_W-1:0]       raddr;
	logic [WORD_W-1:0]      rdata;
	logic [WORD_W-1:0]      wdata;
	logic [SAMPLE_BITS-1:0] rd_avg;
	logic [SUM_BITS-1:0]    rd_sum;
	logic [31:0]            smp_wide;
	logic [SAMPLE_BITS-1:0] smp_w;
	logic [SUM_BITS:0]      sum_ext;
	logic [SUM_BITS-1:0]    avg_full;
	logic [SAMPLE_BITS-1:0] avg_clip;
	logic                   div_busy;
	logic                   div_done;
	logic [PROD_W-1:0]      quotient;

	// Channel count clamped to the range the memory holds.
	always_comb begin
		if (num_ch_q == '0) begin
			active = CNT_W'(1);
		end else if (32'(num_ch_q) > MAX_CHANNELS) begin
			active = CNT_W'(MAX_CHANNELS);
		end else begin
			active = CNT_W'(num_ch_q);
		end
	end

	// Scan index checks and channel range checks.
	assign idx_eff  = (32'(scan_idx_q) >= 32'(active)) ? '0 : scan_idx_q;
	assign idx_next = CNT_W'(scan_idx_q) + CNT_W'(1);
	assign wrap     = (idx_next >= active);
	assign ch_bad   = (32'(ch_q) >= 32'(active));
	assign ref_bad  = (32'(ref_ch_q) >= 32'(active));

	// Read address selection for the filter memory.
	always_comb begin
		case (cmd.rd_sel)
			adcsc_pkg::RD_SCAN: raddr = idx_eff;
			adcsc_pkg::RD_CHAN: raddr = IDX_W'(ch_q);
			adcsc_pkg::RD_REF:  raddr = IDX_W'(ref_ch_q);
			default:            raddr = idx_eff;
		endcase
	end

	// Memory word fields; an entry never written reads as zero.
	assign rd_avg = rd_vld_q ? rdata[SUM_BITS +: SAMPLE_BITS] : '0;
	assign rd_sum = rd_vld_q ? rdata[SUM_BITS-1:0] : '0;

	// Sample taken to the internal width.
	assign smp_wide = 32'(smp_q);
	assign smp_w    = smp_wide[SAMPLE_BITS-1:0];
	assign sum_ext  = {1'b0, rd_sum} + (SUM_BITS + 1)'(smp_w);

	// Average out of the saturated sum, clipped to the sample range.
	assign avg_full = sum_q >> shift_q;
	assign avg_clip = (avg_full > SAMPLE_MAX_S) ? {SAMPLE_BITS{1'b1}}
		: avg_full[SAMPLE_BITS-1:0];
	assign wdata    = {avg_clip, sum_q - SUM_BITS'(avg_clip)};

	adcsc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_CHANNELS)
	) u_ram (
		.clk   (clk),
		.we    (cmd.fold_write),
		.waddr (scan_idx_q),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	adcsc_div #(
		.DEN_W (SAMPLE_BITS),
		.NUM_W (PROD_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (den_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ch_q <= adcsc_pkg::RST_NUM_CH;
			shift_q  <= adcsc_pkg::RST_SHIFT;
			auto_q   <= adcsc_pkg::RST_AUTO;
			ref_ch_q <= adcsc_pkg::RST_REF_CH;
			ref_mv_q <= adcsc_pkg::RST_REF_MV;
		end else if (cfg_we) begin
			case (cfg_addr)
				adcsc_pkg::CFG_NUM_CH: num_ch_q <= cfg_data[adcsc_pkg::NUMCH_W-1:0];
				adcsc_pkg::CFG_SHIFT:  shift_q  <= cfg_data[adcsc_pkg::SHIFT_W-1:0];
				adcsc_pkg::CFG_AUTO:   auto_q   <= cfg_data[0];
				adcsc_pkg::CFG_REF_CH: ref_ch_q <= cfg_data[adcsc_pkg::CHAN_W-1:0];
				adcsc_pkg::CFG_REF_MV: ref_mv_q <= cfg_data[adcsc_pkg::MV_W-1:0];
				default: ;
			endcase
		end
	end

	// Scan state, valid bits and the output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_en_q  <= 1'b0;
			pend_q     <= 1'b0;
			scan_idx_q <= '0;
			valid_q    <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cmd.poll_norm) begin
				scan_idx_q <= idx_eff;
			end
			if (cmd.poll_start) begin
				pend_q <= 1'b1;
			end
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
				pend_q     <= 1'b0;
				scan_en_q  <= 1'b1;
			end
			if (cmd.scan_pause) begin
				scan_en_q <= 1'b0;
			end
			if (cmd.fold_write) begin
				pend_q              <= 1'b0;
				valid_q[scan_idx_q] <= 1'b1;
				if (wrap) begin
					scan_idx_q <= '0;
					scan_en_q  <= auto_q;
				end else begin
					scan_idx_q <= idx_next[IDX_W-1:0];
				end
			end
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Item capture, working registers and result word assembly.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= s_tuser;
			done_q <= s_tdata[0];
			smp_q  <= s_tdata[12:1];
			ch_q   <= s_tdata[15:13];
			res_q  <= '0;
		end
		if (cmd.rd_en) begin
			rd_vld_q <= valid_q[raddr];
		end
		if (cmd.poll_start) begin
			res_q.start_conv   <= 1'b1;
			res_q.conv_channel <= adcsc_pkg::CHAN_W'(idx_eff);
		end
		if (cmd.fold_sum) begin
			sum_q <= sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
		end
		if (cmd.fold_write) begin
			res_q.release_conv <= 1'b1;
			res_q.conv_channel <= adcsc_pkg::CHAN_W'(scan_idx_q);
			res_q.scan_done    <= wrap;
		end
		if (cmd.res_avg) begin
			res_q.read_value <= ch_bad ? '0 : adcsc_pkg::RV_W'(rd_avg);
		end
		if (cmd.cap_den) begin
			den_q <= ref_bad ? '0 : rd_avg;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(ch_bad ? '0 : rd_avg) * PROD_W'(ref_mv_q);
		end
		if (div_done) begin
			if ((den_q == '0) || (|quotient[PROD_W-1:adcsc_pkg::RV_W])) begin
				res_q.read_value <= adcsc_pkg::RV_SAT;
			end else begin
				res_q.read_value <= quotient[adcsc_pkg::RV_W-1:0];
			end
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	// Status back to the controller.
	assign sts.func      = func_q;
	assign sts.conv_done = done_q;
	assign sts.scan_en   = scan_en_q;
	assign sts.pending   = pend_q;
	assign sts.div_busy  = div_busy;
	assign sts.div_done  = div_done;
	assign sts.out_free  = !out_vld_q || m_tready;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = adcsc_pkg::OUT_DATA_W'(out_q);

endmodule

// ----- sv/adcsc_ctrl.sv -----
// Controller state machine that sequences each input word through the datapath.
`timescale 1ns / 1ps

module adcsc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  adcsc_pkg::dp_status_t sts,
	output adcsc_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b0000000001,
		ST_DECODE   = 10'b0000000010,
		ST_FOLD_SUM = 10'b0000000100,
		ST_FOLD_WR  = 10'b0000001000,
		ST_AVG      = 10'b0000010000,
		ST_REF      = 10'b0000100000,
		ST_MUL      = 10'b0001000000,
		ST_DIV_GO   = 10'b0010000000,
		ST_DIV_WAIT = 10'b0100000000,
		ST_RESULT   = 10'b1000000000
	} state_t;

	state_t st_q;
	state_t st_d;

	assign s_tready = (st_q == ST_IDLE);

	// Next state and command decode.
	always_comb begin
		st_d       = st_q;
		cmd        = '0;
		cmd.rd_sel = adcsc_pkg::RD_SCAN;
		case (st_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					st_d      = ST_DECODE;
				end
			end
			ST_DECODE: begin
				st_d = ST_RESULT;
				case (sts.func)
					adcsc_pkg::FUNC_POLL: begin
						if (sts.scan_en) begin
							cmd.poll_norm = 1'b1;
							if (!sts.pending) begin
								cmd.poll_start = 1'b1;
							end else if (sts.conv_done) begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = adcsc_pkg::RD_SCAN;
								st_d       = ST_FOLD_SUM;
							end
						end
					end
					adcsc_pkg::FUNC_START: cmd.scan_start = 1'b1;
					adcsc_pkg::FUNC_PAUSE: cmd.scan_pause = 1'b1;
					adcsc_pkg::FUNC_AVG: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = adcsc_pkg::RD_CHAN;
						st_d       = ST_AVG;
					end
					adcsc_pkg::FUNC_MV: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = adcsc_pkg::RD_REF;
						st_d       = ST_REF;
					end
					default: ;
				endcase
			end
			ST_FOLD_SUM: begin
				cmd.fold_sum = 1'b1;
				st_d         = ST_FOLD_WR;
			end
			ST_FOLD_WR: begin
				cmd.fold_write = 1'b1;
				st_d           = ST_RESULT;
			end
			ST_AVG: begin
				cmd.res_avg = 1'b1;
				st_d        = ST_RESULT;
			end
			ST_REF: begin
				cmd.cap_den = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = adcsc_pkg::RD_CHAN;
				st_d        = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				st_d    = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				st_d          = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					st_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					st_d         = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// An accepted word is decoded in the next cycle.
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE && s_tvalid) |=> (st_q == ST_DECODE))
		else $error("accepted word was not decoded");

	// A finished result waits while the output register is still full.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RESULT && !sts.out_free) |=> (st_q == ST_RESULT))
		else $error("result left while the output register was occupied");

	// The divider runs once it has been started.
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV_GO) |=> sts.div_busy)
		else $error("divider did not start");

endmodule

// ----- bench/tb_adc_scan_with_channel_averaging.sv -----
// Self-checking testbench of the ADC scan controller with per-channel leaky-sum averaging.
`timescale 1ns / 1ps

module tb_adc_scan_with_channel_averaging;

	localparam int MAX_CH     = 8;
	localparam int SMP_BITS   = 12;
	localparam int SUM_W      = 24;
	localparam int SMP_TOP    = (1 << SMP_BITS) - 1;
	localparam int PHASES     = 9;
	localparam int PHASE_WORDS = 100;
	// Cycles that cover the slowest word (a millivolt read) once the queue has drained.
	localparam int SETTLE_CYCLES = 60;

	// Scan and filter predictor with the queue of result words still to come.
	class scan_scoreboard;
		logic [adcsc_pkg::NUMCH_W-1:0] num_ch;
		logic [adcsc_pkg::SHIFT_W-1:0] shift;
		logic                          auto_rs;
		logic [adcsc_pkg::CHAN_W-1:0]  ref_ch;
		logic [adcsc_pkg::MV_W-1:0]    ref_mv;
		logic                          scan_en;
		logic                          conv_pending;
		int                            scan_idx;
		logic [SUM_W-1:0]              sums [MAX_CH];
		logic [11:0]                   avgs [MAX_CH];
		adcsc_pkg::out_word_t          result_q [$];
		int                            errors;

		function new();
			num_ch = adcsc_pkg::RST_NUM_CH;
			shift = adcsc_pkg::RST_SHIFT;
			auto_rs = adcsc_pkg::RST_AUTO;
			ref_ch = adcsc_pkg::RST_REF_CH;
			ref_mv = adcsc_pkg::RST_REF_MV;
			scan_en = 1'b0;
			conv_pending = 1'b0;
			scan_idx = 0;
			for (int i = 0; i < MAX_CH; i++) begin
				sums[i] = '0;
				avgs[i] = '0;
			end
			errors = 0;
		endfunction

		function void write_reg(logic [adcsc_pkg::CFG_ADDR_W-1:0] idx,
				logic [adcsc_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				adcsc_pkg::CFG_NUM_CH: num_ch = val[adcsc_pkg::NUMCH_W-1:0];
				adcsc_pkg::CFG_SHIFT:  shift = val[adcsc_pkg::SHIFT_W-1:0];
				adcsc_pkg::CFG_AUTO:   auto_rs = val[0];
				adcsc_pkg::CFG_REF_CH: ref_ch = val[adcsc_pkg::CHAN_W-1:0];
				adcsc_pkg::CFG_REF_MV: ref_mv = val[adcsc_pkg::MV_W-1:0];
				default: ;
			endcase
		endfunction

		// A zero count acts as one channel, a count above the maximum as the maximum.
		function int active_channels();
			if (num_ch == 0) return 1;
			if (num_ch > MAX_CH) return MAX_CH;
			return int'(num_ch);
		endfunction

		// Channels outside the scan list read as zero.
		function int avg_of(int ch);
			if (ch >= active_channels()) return 0;
			return int'(avgs[ch]);
		endfunction

		// Leaky sum: add the sample with saturation, take the shifted average, clip it
		// to the sample range and remove it from the sum.
		function void fold(int ch, logic [11:0] smp);
			logic [SUM_W:0] s;
			logic [SUM_W:0] a;
			s = {1'b0, sums[ch]} + (SUM_W + 1)'(smp);
			if (s > {1'b0, {SUM_W{1'b1}}}) s = {1'b0, {SUM_W{1'b1}}};
			a = s >> shift;
			if (a > SMP_TOP) a = (SUM_W + 1)'(SMP_TOP);
			sums[ch] = SUM_W'(s - a);
			avgs[ch] = a[11:0];
		endfunction

		function void note_input(logic [adcsc_pkg::FUNC_W-1:0] f, logic d,
				logic [11:0] smp, logic [adcsc_pkg::CHAN_W-1:0] ch);
			adcsc_pkg::out_word_t e;
			longint q;
			int refv;
			e = '0;
			case (f)
				adcsc_pkg::FUNC_POLL: begin
					if (scan_en) begin
						if (scan_idx >= active_channels()) scan_idx = 0;
						if (!conv_pending) begin
							e.start_conv = 1'b1;
							e.conv_channel = scan_idx[adcsc_pkg::CHAN_W-1:0];
							conv_pending = 1'b1;
						end else if (d) begin
							e.release_conv = 1'b1;
							e.conv_channel = scan_idx[adcsc_pkg::CHAN_W-1:0];
							conv_pending = 1'b0;
							fold(scan_idx, smp);
							scan_idx++;
							if (scan_idx >= active_channels()) begin
								scan_idx = 0;
								e.scan_done = 1'b1;
								scan_en = auto_rs;
							end
						end
					end
				end
				adcsc_pkg::FUNC_START: begin
					scan_idx = 0;
					conv_pending = 1'b0;
					scan_en = 1'b1;
				end
				adcsc_pkg::FUNC_PAUSE: scan_en = 1'b0;
				adcsc_pkg::FUNC_AVG: e.read_value = 16'(avg_of(int'(ch)));
				adcsc_pkg::FUNC_MV: begin
					refv = avg_of(int'(ref_ch));
					if (refv == 0) begin
						e.read_value = adcsc_pkg::RV_SAT;
					end else begin
						q = (longint'(avg_of(int'(ch))) * longint'(ref_mv)) / refv;
						e.read_value = (q > 65535) ? adcsc_pkg::RV_SAT : q[15:0];
					end
				end
				default: ;
			endcase
			result_q.push_back(e);
		endfunction

		function void report(string field, logic [15:0] e, logic [15:0] a);
			if (e !== a) begin
				$display("%0t: %s expected %0d actual %0d", $time, field, e, a);
				errors++;
			end
		endfunction

		function void check_result(logic [adcsc_pkg::OUT_DATA_W-1:0] w);
			adcsc_pkg::out_word_t e;
			adcsc_pkg::out_word_t a;
			if (result_q.size() == 0) begin
				$display("%0t: result word %h expected none actual one", $time, w);
				errors++;
				return;
			end
			e = result_q.pop_front();
			a = w[$bits(adcsc_pkg::out_word_t)-1:0];
			report("start_conv", 16'(e.start_conv), 16'(a.start_conv));
			report("conv_channel", 16'(e.conv_channel), 16'(a.conv_channel));
			report("release_conv", 16'(e.release_conv), 16'(a.release_conv));
			report("scan_done", 16'(e.scan_done), 16'(a.scan_done));
			report("read_value", e.read_value, a.read_value);
			report("zero fill", 16'd0,
				16'(w[adcsc_pkg::OUT_DATA_W-1:$bits(adcsc_pkg::out_word_t)]));
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [adcsc_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [adcsc_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [adcsc_pkg::IN_DATA_W-1:0]  s_tdata;
	logic [adcsc_pkg::FUNC_W-1:0]     s_tuser;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [adcsc_pkg::OUT_DATA_W-1:0] m_tdata;

	scan_scoreboard sb;
	int  tx_idle_pct;
	int  rx_idle_pct;
	bit  low_ref;

	adc_scan_with_channel_averaging #(
		.MAX_CHANNELS(MAX_CH),
		.SAMPLE_BITS(SMP_BITS),
		.SUM_BITS(SUM_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Clock with a 20 ns period.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Generous watchdog on the whole run.
	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: check every accepted word and stall at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Offer one command word, idling at random first, and note it once accepted.
	task automatic send_word(logic [adcsc_pkg::FUNC_W-1:0] f, logic d, logic [11:0] smp,
			logic [adcsc_pkg::CHAN_W-1:0] ch);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= {ch, smp, d};
		do @(posedge clk); while (!s_tready);
		sb.note_input(f, d, smp, ch);
	endtask

	task automatic write_reg(logic [adcsc_pkg::CFG_ADDR_W-1:0] idx,
			logic [adcsc_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic apply_config(int nc, int sh, int au, int rc, int mv);
		write_reg(adcsc_pkg::CFG_NUM_CH, 12'(nc));
		write_reg(adcsc_pkg::CFG_SHIFT, 12'(sh));
		write_reg(adcsc_pkg::CFG_AUTO, 12'(au));
		write_reg(adcsc_pkg::CFG_REF_CH, 12'(rc));
		write_reg(adcsc_pkg::CFG_REF_MV, 12'(mv));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Stop sending and let every expected word arrive, then let the block settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.result_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Extremes are frequent; the reference channel may be kept small to push
	// millivolt reads into saturation.
	function automatic logic [11:0] pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (low_ref && sb.scan_idx == sb.ref_ch) return 12'($urandom_range(0, 20));
		if (r < 10) return '0;
		if (r < 20) return 12'(SMP_TOP);
		return 12'($urandom_range(0, SMP_TOP));
	endfunction

	// Mostly well-formed polls that follow the conversion handshake, mixed with
	// starts, pauses, reads and unused codes.
	task automatic random_word(output bit counted);
		int r;
		logic [adcsc_pkg::FUNC_W-1:0] f;
		logic d;
		logic [11:0] smp;
		logic [adcsc_pkg::CHAN_W-1:0] ch;
		r = $urandom_range(0, 99);
		d = 1'($urandom_range(0, 1));
		smp = pick_sample();
		ch = 3'($urandom_range(0, MAX_CH - 1));
		if (r < 70) begin
			f = adcsc_pkg::FUNC_POLL;
			if (!sb.scan_en && $urandom_range(0, 99) < 60) f = adcsc_pkg::FUNC_START;
			else if (sb.conv_pending) d = ($urandom_range(0, 99) < 80);
		end else if (r < 73) begin
			f = adcsc_pkg::FUNC_START;
		end else if (r < 76) begin
			f = adcsc_pkg::FUNC_PAUSE;
		end else if (r < 86) begin
			f = adcsc_pkg::FUNC_AVG;
		end else if (r < 96) begin
			f = adcsc_pkg::FUNC_MV;
			if (r < 89) ch = sb.ref_ch;
		end else begin
			f = 3'(32'(adcsc_pkg::FUNC_MV) + 1 + $urandom_range(0, 2));
		end
		counted = (f <= adcsc_pkg::FUNC_MV) && !(f == adcsc_pkg::FUNC_POLL && !sb.scan_en);
		send_word(f, d, smp, ch);
	endtask

	initial begin
		bit counted;
		int done_words;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = adcsc_pkg::FUNC_POLL;
		tx_idle_pct = 15;
		rx_idle_pct = 15;
		low_ref = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings.
		send_word(adcsc_pkg::FUNC_MV, 1'b0, '0, 3'd0);              // zero reference saturates
		send_word(adcsc_pkg::FUNC_AVG, 1'b1, 12'(SMP_TOP), 3'd7);
		send_word(adcsc_pkg::FUNC_POLL, 1'b1, 12'(SMP_TOP), 3'd0);  // scan idle
		send_word(adcsc_pkg::FUNC_MV + 3'd1, 1'b1, 12'(SMP_TOP), 3'd7); // unused codes
		send_word(adcsc_pkg::FUNC_MV + 3'd3, 1'b0, '0, 3'd0);
		send_word(adcsc_pkg::FUNC_START, 1'b0, '0, 3'd0);
		send_word(adcsc_pkg::FUNC_POLL, 1'b0, '0, 3'd0);            // conversion start
		send_word(adcsc_pkg::FUNC_POLL, 1'b0, 12'(SMP_TOP), 3'd0);  // still waiting
		send_word(adcsc_pkg::FUNC_POLL, 1'b1, 12'(SMP_TOP), 3'd0);  // fold
		send_word(adcsc_pkg::FUNC_POLL, 1'b0, '0, 3'd0);
		send_word(adcsc_pkg::FUNC_PAUSE, 1'b0, '0, 3'd0);
		send_word(adcsc_pkg::FUNC_POLL, 1'b1, 12'd1234, 3'd0);      // paused, pending kept
		send_word(adcsc_pkg::FUNC_START, 1'b0, '0, 3'd0);
		// One full scan ending in scan done and an automatic restart.
		for (int i = 0; i < MAX_CH; i++) begin
			send_word(adcsc_pkg::FUNC_POLL, 1'b0, '0, 3'd0);
			send_word(adcsc_pkg::FUNC_POLL, 1'b1, (i % 2 == 0) ? 12'(SMP_TOP) : 12'd0,
				3'd0);
		end
		send_word(adcsc_pkg::FUNC_MV, 1'b0, '0, 3'd0);
		send_word(adcsc_pkg::FUNC_AVG, 1'b0, '0, 3'd6);
		drain();

		// Random phases, the first few at fixed and extreme settings.
		for (int p = 0; p < PHASES; p++) begin
			tx_idle_pct = 15;
			rx_idle_pct = 15;
			low_ref = 1'b0;
			case (p)
				0: begin
					apply_config(8, 7, 1, 6, 4095);
					low_ref = 1'b1;
				end
				1: apply_config(8, 0, 0, 0, 1);
				2: begin
					apply_config(1, 3, 1, 0, 1650);
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
				3: apply_config(0, 5, 1, 7, 2000);
				4: apply_config(15, 1, 0, 3, 0);
				default: begin
					apply_config(($urandom_range(0, 99) < 70) ? $urandom_range(1, 8)
							: $urandom_range(0, 15),
						$urandom_range(0, 7), $urandom_range(0, 1),
						$urandom_range(0, 7), $urandom_range(0, 4095));
					low_ref = 1'($urandom_range(0, 1));
				end
			endcase
			done_words = 0;
			while (done_words < PHASE_WORDS) begin
				random_word(counted);
				if (counted) done_words++;
			end
			drain();
		end

		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
